[sv/tdpt_pkg.sv]
// shared constants and types for the trial division prime test
// used by tdpt_div and trial_division_prime_test_top
package tdpt_pkg;

    localparam int VALUE_BITS = 31;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [VALUE_BITS-1:0] rem;
    } div_stat_t;

endpackage

[sv/tdpt_div.sv]
// serial restoring divider, one quotient bit per cycle
// depends on tdpt_pkg for widths and the status struct
module tdpt_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tdpt_pkg::VALUE_BITS-1:0] dividend,
    input  logic [tdpt_pkg::VALUE_BITS-1:0] divisor,
    output tdpt_pkg::div_stat_t             stat
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [tdpt_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [tdpt_pkg::VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [tdpt_pkg::VALUE_BITS-1:0]  rem_reg, rem_next;
    logic [tdpt_pkg::VALUE_BITS-1:0]  dvs_reg, dvs_next;
    logic [tdpt_pkg::VALUE_BITS:0]    trial;
    logic [tdpt_pkg::VALUE_BITS:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, acc_reg[tdpt_pkg::VALUE_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_BITS);
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder only if the subtract did not borrow
            if (!diff[tdpt_pkg::VALUE_BITS])
            begin
                rem_next = diff[tdpt_pkg::VALUE_BITS-1:0];
                acc_next = {acc_reg[tdpt_pkg::VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[tdpt_pkg::VALUE_BITS-1:0];
                acc_next = {acc_reg[tdpt_pkg::VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - tdpt_pkg::CNT_W'(1);
            if (cnt_reg == tdpt_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = acc_reg;
    assign stat.rem  = rem_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");
`endif

endmodule

[sv/trial_division_prime_test_top.sv]
// trial division prime test: sequencer, divisor register and output word
// depends on tdpt_pkg and tdpt_div
//
// usage: one input word (candidate) gives one output word (is_prime)
// input channel: in_valid / in_stall, word taken when in_valid && !in_stall
// output channel: out_valid / out_stall, word taken when out_valid && !out_stall
// in_stall is high from acceptance until the result is in the output register
// candidates below 2 skip the divider and go straight to the deliver state
// otherwise divisors 2, 3, ... are tried while divisor <= candidate / divisor;
// each try is one pass of the shared serial divider; a prime n takes
// floor(sqrt(n)) tries before its result is delivered
// a composite stops at its smallest factor p after p - 1 tries
// the output register holds a finished word while out_stall is high; the next
// candidate may be accepted meanwhile, its result waits until the register frees
// reset (rst_n low, asynchronous) clears out_valid and returns to idle
module trial_division_prime_test_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tdpt_pkg::VALUE_BITS-1:0] candidate,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_prime
);

    tdpt_pkg::state_t                state_reg, state_next;
    logic [tdpt_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [tdpt_pkg::VALUE_BITS-1:0] divisor_reg, divisor_next;
    logic                            result_reg, result_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            is_prime_reg, is_prime_next;
    logic                            div_start;
    tdpt_pkg::div_stat_t             div_stat;

    tdpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (divisor_reg),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        divisor_next   = divisor_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        div_start      = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next   = candidate;
                    divisor_next = tdpt_pkg::VALUE_BITS'(2);
                    if (candidate < tdpt_pkg::VALUE_BITS'(2))
                    begin
                        result_next = 1'b0;
                        state_next  = tdpt_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        state_next = tdpt_pkg::ST_START;
                    end
                end
            end
            tdpt_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = tdpt_pkg::ST_WAIT;
            end
            tdpt_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    // bound test first: divisor past value / divisor means no factor left
                    priority if (divisor_reg > div_stat.quot)
                    begin
                        result_next = 1'b1;
                        state_next  = tdpt_pkg::ST_DELIVER;
                    end
                    else if (div_stat.rem == '0)
                    begin
                        result_next = 1'b0;
                        state_next  = tdpt_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        divisor_next = divisor_reg + tdpt_pkg::VALUE_BITS'(1);
                        state_next   = tdpt_pkg::ST_START;
                    end
                end
            end
            tdpt_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = result_reg;
                    state_next     = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        divisor_reg  <= divisor_next;
        result_reg   <= result_next;
        is_prime_reg <= is_prime_next;
    end

    assign in_stall  = (state_reg != tdpt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

`ifndef SYNTHESIS
    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdpt_pkg::ST_START || state_reg == tdpt_pkg::ST_WAIT)
        |-> (divisor_reg >= tdpt_pkg::VALUE_BITS'(2)))
        else $error("divisor below two during search");
    a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdpt_pkg::ST_DELIVER && value_reg < tdpt_pkg::VALUE_BITS'(2))
        |-> !result_reg)
        else $error("value below two marked prime");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == tdpt_pkg::ST_WAIT))
        else $error("divider finished outside wait state");
    a_start_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdpt_pkg::ST_START) |=> (state_reg == tdpt_pkg::ST_WAIT))
        else $error("division start not followed by wait");
`endif

endmodule

[test/trial_division_prime_test_top_tb.sv]
// testbench for trial_division_prime_test_top: drives candidate words, predicts
// is_prime by trial division and checks each output word in order
// depends on tdpt_pkg and trial_division_prime_test_top
module trial_division_prime_test_top_tb;

    localparam int VB            = tdpt_pkg::VALUE_BITS;
    localparam int HALF_PERIOD   = 4;
    localparam int IDLE_PCT      = 27;
    localparam int RANDOM_WORDS  = 100;
    localparam int HOLD_CYCLES   = 80_000;
    localparam int HOLD_AT       = 30;
    localparam int DRAIN_CYCLES  = 200;
    localparam int LIMIT_TIME    = 200_000_000;

    class prime_scoreboard;
        bit expected_q[$];
        int errors;
        int results_seen;

        // divisor <= value / divisor keeps the bound free of overflow
        function bit trial_divide_prime(logic [VB-1:0] value);
            longint unsigned number;
            longint unsigned divisor;
            number = 64'(value);
            if (number < 2)
                return 1'b0;
            for (divisor = 2; divisor <= number / divisor; divisor++)
            begin
                if (number % divisor == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_input(logic [VB-1:0] value);
            expected_q.push_back(trial_divide_prime(value));
        endfunction

        function void check_result(logic got);
            bit want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("is_prime: no word expected, actual %0b", got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $error("is_prime: expected %0b actual %0b", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    logic [VB-1:0] candidate = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          is_prime;

    prime_scoreboard board = new();
    int            words_sent;
    bit            hold_done;
    int            hold_left;

    trial_division_prime_test_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    always #HALF_PERIOD clk = ~clk;

    // a stretch of words goes out with no idle cycles at all
    task automatic send_word(input logic [VB-1:0] value);
        bit quiet;
        quiet = (words_sent >= 40 && words_sent < 70);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(value);
        words_sent++;
    endtask

    // mostly small values; the largest ones are built with a small factor so the
    // divider loop stays short
    function automatic logic [VB-1:0] pick_candidate();
        int unsigned     kind;
        int unsigned     factor;
        longint unsigned wide;
        logic [VB-1:0]   trimmed;
        kind = $urandom_range(99);
        if (kind < 40)
            wide = 64'($urandom_range(1023));
        else if (kind < 65)
            wide = 64'($urandom_range(65535));
        else if (kind < 85)
        begin
            factor  = $urandom_range(13, 2);
            wide    = {$urandom, $urandom};
            trimmed = wide[VB-1:0];
            trimmed = VB'(trimmed - trimmed % factor);
            wide    = 64'(trimmed);
        end
        else if (kind < 95)
            wide = longint'($urandom_range(1000, 2)) * longint'($urandom_range(1000, 2));
        else
            wide = 64'($urandom_range((1 << 20) - 1));
        return wide[VB-1:0];
    endfunction

    // receiver: checks accepted words, then picks the next stall value
    initial
    begin
        hold_done = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(is_prime);
            if (!hold_done && board.results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (board.results_seen >= 50 && board.results_seen < 80)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        longint unsigned directed[$];
        directed = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121, 169, 105, 7919,
                     1018081, 1000003, 2000006, 16777213};
        directed.push_back(longint'({VB{1'b1}}) - 1);
        directed.push_back(longint'({VB{1'b1}}) - 2);
        directed.push_back(longint'(1) << (VB - 1));
        words_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_word(VB'(directed[i]));
        repeat (RANDOM_WORDS)
            send_word(pick_candidate());
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #LIMIT_TIME;
        $display("simulation failed");
        $finish;
    end

endmodule
